// ===== rtl/biq_pkg.sv =====
package biq_pkg;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_A0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_A1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_A2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B1 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B2 = 3'd5;

    // multiplier operand select: the five taps, then the gain
    typedef enum logic [2:0] {
        SEL_A0   = 3'd0,
        SEL_A1   = 3'd1,
        SEL_A2   = 3'd2,
        SEL_B1   = 3'd3,
        SEL_B2   = 3'd4,
        SEL_GAIN = 3'd5
    } op_sel_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_LAST = 5'b00100,
        ST_GAIN = 5'b01000,
        ST_RND  = 5'b10000
    } biq_state_t;

    typedef struct packed {
        logic    clear_acc;
        logic    mul_en;
        op_sel_t sel;
        logic    acc_en;
    } mac_ctrl_t;

endpackage

// ===== rtl/biq_ctrl.sv =====
module biq_ctrl
    import biq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      out_busy,
    output logic      in_ready,
    output logic      done,
    output mac_ctrl_t ctrl
);

    biq_state_t state_reg;
    biq_state_t state_next;
    logic [2:0] cnt_reg;
    logic [2:0] cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        in_ready       = 1'b0;
        done           = 1'b0;
        ctrl.clear_acc = 1'b0;
        ctrl.mul_en    = 1'b0;
        ctrl.sel       = op_sel_t'(cnt_reg);
        ctrl.acc_en    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cnt_next = 3'd0;
                if (in_valid)
                begin
                    ctrl.clear_acc = 1'b1;
                    state_next     = ST_MUL;
                end
            end
            ST_MUL:
            begin
                ctrl.mul_en = 1'b1;
                ctrl.acc_en = (cnt_reg != 3'd0);
                cnt_next    = cnt_reg + 3'd1;
                if (op_sel_t'(cnt_reg) == SEL_B2)
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                ctrl.acc_en = 1'b1;
                state_next  = ST_GAIN;
            end
            ST_GAIN:
            begin
                ctrl.mul_en = 1'b1;
                ctrl.sel    = SEL_GAIN;
                state_next  = ST_RND;
            end
            ST_RND:
            begin
                if (!out_busy)
                begin
                    done       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/biq_mac.sv =====
module biq_mac
    import biq_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int COEF_WIDTH   = 18
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  mac_ctrl_t                      ctrl,
    input  logic signed [COEF_WIDTH-1:0]   gain,
    input  logic signed [COEF_WIDTH-1:0]   coef_a0,
    input  logic signed [COEF_WIDTH-1:0]   coef_a1,
    input  logic signed [COEF_WIDTH-1:0]   coef_a2,
    input  logic signed [COEF_WIDTH-1:0]   coef_b1,
    input  logic signed [COEF_WIDTH-1:0]   coef_b2,
    input  logic signed [SAMPLE_WIDTH-1:0] x0,
    input  logic signed [SAMPLE_WIDTH-1:0] x1,
    input  logic signed [SAMPLE_WIDTH-1:0] x2,
    input  logic signed [SAMPLE_WIDTH-1:0] y1,
    input  logic signed [SAMPLE_WIDTH-1:0] y2,
    output logic signed [SAMPLE_WIDTH-1:0] y_sat
);

    localparam int PROD_W = COEF_WIDTH + SAMPLE_WIDTH;
    localparam int PRE    = (PROD_W > 58) ? PROD_W - 58 : 0;
    localparam int TERM_W = PROD_W - PRE;
    localparam int SUM_W  = TERM_W + 3;
    localparam int R_RAW  = 2 * COEF_WIDTH + SAMPLE_WIDTH + 1 - PRE - 62;
    localparam int R      = (R_RAW > 0) ? R_RAW : 0;
    localparam int ACCS_W = SUM_W - R;
    localparam int S      = 2 * (COEF_WIDTH - 4) - PRE - R;
    localparam int GP_W   = ACCS_W + COEF_WIDTH;
    localparam int MA_W   = (ACCS_W > COEF_WIDTH) ? ACCS_W : COEF_WIDTH;
    localparam int MB_W   = (SAMPLE_WIDTH > COEF_WIDTH) ? SAMPLE_WIDTH : COEF_WIDTH;
    localparam int MP_W   = MA_W + MB_W;
    localparam int SH_W   = GP_W + 1 - S;
    localparam logic signed [GP_W:0] RND_HALF = (GP_W + 1)'(1) << (S - 1);
    localparam logic signed [SAMPLE_WIDTH-1:0] SAT_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SAT_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [MP_W-1:0]   prod_reg;
    logic signed [MP_W-1:0]   prod_next;
    logic signed [SUM_W-1:0]  acc_reg;
    logic signed [SUM_W-1:0]  term;
    logic signed [ACCS_W-1:0] acc_shr;
    logic signed [GP_W-1:0]   gp;
    logic signed [GP_W:0]     rnd;
    logic signed [SH_W-1:0]   shifted;
    logic [SH_W-SAMPLE_WIDTH:0] upper;

    assign acc_shr = $signed(acc_reg[SUM_W-1:R]);

    always_comb
    begin
        mul_a = MA_W'(coef_a0);
        mul_b = MB_W'(x0);
        case (ctrl.sel)
            SEL_A0:
            begin
                mul_a = MA_W'(coef_a0);
                mul_b = MB_W'(x0);
            end
            SEL_A1:
            begin
                mul_a = MA_W'(coef_a1);
                mul_b = MB_W'(x1);
            end
            SEL_A2:
            begin
                mul_a = MA_W'(coef_a2);
                mul_b = MB_W'(x2);
            end
            SEL_B1:
            begin
                mul_a = MA_W'(coef_b1);
                mul_b = MB_W'(y1);
            end
            SEL_B2:
            begin
                mul_a = MA_W'(coef_b2);
                mul_b = MB_W'(y2);
            end
            SEL_GAIN:
            begin
                mul_a = MA_W'(acc_shr);
                mul_b = MB_W'(gain);
            end
            default:
            begin
                mul_a = MA_W'(coef_a0);
                mul_b = MB_W'(x0);
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;
    assign term      = SUM_W'($signed(prod_reg[PROD_W-1:PRE]));

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= prod_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.clear_acc)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.acc_en)
        begin
            acc_reg <= acc_reg + term;
        end
    end

    // round half up, then saturate
    assign gp      = $signed(prod_reg[GP_W-1:0]);
    assign rnd     = (GP_W + 1)'(gp) + RND_HALF;
    assign shifted = $signed(rnd[GP_W:S]);
    assign upper   = shifted[SH_W-1:SAMPLE_WIDTH-1];

    always_comb
    begin
        if ((&upper) || !(|upper))
        begin
            y_sat = shifted[SAMPLE_WIDTH-1:0];
        end
        else if (shifted[SH_W-1])
        begin
            y_sat = SAT_MIN;
        end
        else
        begin
            y_sat = SAT_MAX;
        end
    end

endmodule

// ===== rtl/biquad_iir_filter.sv =====
// Second-order direct form I IIR section. Each request on the input
// channel carries one signed sample; one filtered, rounded and saturated
// sample comes back per request. A single shared multiplier forms the five
// tap products and then the gain product; in_ready is low from each
// accepted request until its result is registered, which waits while the
// output register still holds an earlier result for out_ready. The cfg
// port writes coefficients and gain (index 0 gain, 1..3 a0..a2, 4..5
// b1..b2); the user must do so only while the block is idle; not enforced.
// All terms are added, so subtractive feedback uses negative coefficients.
module biquad_iir_filter
    import biq_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int COEF_WIDTH   = 18
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] sample_out,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [CFG_IDX_W-1:0]           cfg_index,
    input  logic signed [COEF_WIDTH-1:0]   cfg_data
);

    localparam logic signed [COEF_WIDTH-1:0] ONE_Q = COEF_WIDTH'(1) << (COEF_WIDTH - 4);

    logic signed [COEF_WIDTH-1:0]   gain_reg;
    logic signed [COEF_WIDTH-1:0]   coef_a0_reg;
    logic signed [COEF_WIDTH-1:0]   coef_a1_reg;
    logic signed [COEF_WIDTH-1:0]   coef_a2_reg;
    logic signed [COEF_WIDTH-1:0]   coef_b1_reg;
    logic signed [COEF_WIDTH-1:0]   coef_b2_reg;
    logic signed [SAMPLE_WIDTH-1:0] x0_reg;
    logic signed [SAMPLE_WIDTH-1:0] x1_reg;
    logic signed [SAMPLE_WIDTH-1:0] x2_reg;
    logic signed [SAMPLE_WIDTH-1:0] y1_reg;
    logic signed [SAMPLE_WIDTH-1:0] y2_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_data_reg;
    logic signed [SAMPLE_WIDTH-1:0] y_sat;
    logic                           out_valid_reg;
    logic                           out_busy;
    logic                           done;
    mac_ctrl_t                      ctrl;

    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign sample_out = out_data_reg;
    assign out_busy   = out_valid_reg && !out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg    <= ONE_Q;
            coef_a0_reg <= ONE_Q;
            coef_a1_reg <= '0;
            coef_a2_reg <= '0;
            coef_b1_reg <= '0;
            coef_b2_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_GAIN:    gain_reg    <= cfg_data;
                REG_COEF_A0: coef_a0_reg <= cfg_data;
                REG_COEF_A1: coef_a1_reg <= cfg_data;
                REG_COEF_A2: coef_a2_reg <= cfg_data;
                REG_COEF_B1: coef_b1_reg <= cfg_data;
                REG_COEF_B2: coef_b2_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            x0_reg <= sample_in;
        end
        if (done)
        begin
            out_data_reg <= y_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1_reg        <= '0;
            x2_reg        <= '0;
            y1_reg        <= '0;
            y2_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (done)
            begin
                x1_reg        <= x0_reg;
                x2_reg        <= x1_reg;
                y1_reg        <= y_sat;
                y2_reg        <= y1_reg;
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    biq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_busy (out_busy),
        .in_ready (in_ready),
        .done     (done),
        .ctrl     (ctrl)
    );

    biq_mac #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH)
    ) u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .gain    (gain_reg),
        .coef_a0 (coef_a0_reg),
        .coef_a1 (coef_a1_reg),
        .coef_a2 (coef_a2_reg),
        .coef_b1 (coef_b1_reg),
        .coef_b2 (coef_b2_reg),
        .x0      (x0_reg),
        .x1      (x1_reg),
        .x2      (x2_reg),
        .y1      (y1_reg),
        .y2      (y2_reg),
        .y_sat   (y_sat)
    );

endmodule

// ===== rtl/biq_checker.sv =====
module biq_checker
#(
    parameter int SAMPLE_WIDTH = 16
)
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic signed [SAMPLE_WIDTH-1:0] sample_out
);

    // held result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample_out))
        else $error("result changed while stalled");

    // busy for the whole sequencer run after a request
    a_busy_run: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready ##1 !in_ready ##1 !in_ready ##1 !in_ready
            ##1 !in_ready ##1 !in_ready ##1 !in_ready ##1 !in_ready)
        else $error("input accepted during computation");

    // a new result only appears as the block goes idle
    a_out_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("result raised while busy");

    a_reset_out: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("out_valid during reset");

endmodule

bind biquad_iir_filter biq_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_biq_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out)
);
